// ===== design/mrdg_pkg.sv =====
// Shared types, constants and helpers of the miss-ratio frequency governor.
`default_nettype none

package mrdg_pkg;

  // Field widths
  localparam int COUNT_W   = 48;
  localparam int FRAC_W    = 16;
  localparam int FREQ_W    = 24;
  localparam int STATUS_W  = 3;
  localparam int JUMP_W    = 5;
  localparam int WIN_CFG_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int TH_W      = FRAC_W + 2;

  // Parameter defaults
  localparam int DEFAULT_WINDOW_MAX = 16;

  // Algorithm constants
  localparam logic [FRAC_W-1:0] JUMP_MARGIN = 16'd6554;
  localparam int JUMP_LIMIT     = 2;
  localparam int DEFAULT_WINDOW = 10;

  // Register reset values
  localparam logic [FRAC_W-1:0] RST_LOWER_THR = 16'd1966;
  localparam logic [FRAC_W-1:0] RST_UPPER_THR = 16'd5243;
  localparam logic [FRAC_W-1:0] RST_HYST_BAND = 16'd328;
  localparam logic [FREQ_W-1:0] RST_MAX_FREQ  = 24'd2400000;
  localparam logic [FREQ_W-1:0] RST_MID_FREQ  = 24'd1800000;
  localparam logic [FREQ_W-1:0] RST_MIN_FREQ  = 24'd1200000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_FREQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FAST       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SMOOTH     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHG_FAST   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CHG_SMOOTH = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CHG_IDLE   = 3'd5;

  typedef struct packed {
    logic [COUNT_W-1:0] miss_count;
    logic [COUNT_W-1:0] instr_count;
    logic [COUNT_W-1:0] cycle_count;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   freq_khz;
    logic                freq_changed;
    logic [STATUS_W-1:0] status;
    logic [FRAC_W-1:0]   ratio_now;
    logic [FRAC_W-1:0]   ratio_average;
    logic [JUMP_W-1:0]   jump_count;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_NB,
    RD_NW
  } rd_sel_e;

  typedef struct packed {
    logic    load_in;
    rd_sel_e rd_sel;
    logic    cap_old;
    logic    cap_nb;
    logic    cap_nw;
    logic    div_start;
    logic    div_avg;
    logic    load_ratio;
    logic    update;
    logic    load_avg;
    logic    decide;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic idle_item;
    logic div_done;
  } dp_stat_t;

  function automatic logic is_jump(logic [FRAC_W-1:0] a, logic [FRAC_W-1:0] b);
    logic [FRAC_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > JUMP_MARGIN;
  endfunction

endpackage

`default_nettype wire

// ===== design/mrdg_frac_div.sv =====
// Shared iterative fraction divider: 16 quotient bits of num/den, one per cycle.
`default_nettype none

module mrdg_frac_div
  import mrdg_pkg::*;
#(
  parameter int DIV_W = COUNT_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_W-1:0]  num_i,
  input  wire logic [DIV_W-1:0]  den_i,
  output logic                   done_o,
  output logic [FRAC_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(FRAC_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAC_W - 1);

  logic [DIV_W-1:0]  rem_q, den_q;
  logic [FRAC_W-1:0] quot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DIV_W:0]    two_rem, diff;
  logic              ge;

  always_comb begin
    two_rem = {rem_q, 1'b0};
    diff    = two_rem - {1'b0, den_q};
    ge      = two_rem >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? DIV_W'(diff) : DIV_W'(two_rem);
      quot_q <= {quot_q[FRAC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== design/mrdg_datapath.sv =====
// Datapath: configuration registers, ratio history, running sum, jump count and decision.
`default_nettype none

module mrdg_datapath
  import mrdg_pkg::*;
#(
  parameter int WINDOW_MAX = DEFAULT_WINDOW_MAX
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data_i,
  input  wire in_item_t              in_data_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  output out_item_t                  out_data_o
);

  localparam int WIN_EFF = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
  localparam int AW      = $clog2(WIN_EFF);
  localparam int WIN_W   = $clog2(WIN_EFF + 1);
  localparam int SUM_W   = $clog2(WIN_EFF * 65535 + 1);
  localparam int DIV_W   = (COUNT_W > WIN_W + FRAC_W) ? COUNT_W : WIN_W + FRAC_W;
  localparam int TS_W    = WIN_W + 2;
  localparam logic [WIN_W-1:0] W_RST =
    WIN_W'((DEFAULT_WINDOW > WIN_EFF) ? WIN_EFF : DEFAULT_WINDOW);
  localparam logic [WIN_W-1:0] W_MAX = WIN_W'(WIN_EFF);

  // Configuration
  logic [FRAC_W-1:0] lower_thr_q, upper_thr_q, hyst_q;
  logic [FREQ_W-1:0] max_freq_q, mid_freq_q, min_freq_q;
  logic [WIN_W-1:0]  win_q, win_wr;
  logic [WIN_CFG_W-1:0] win_raw;

  // History state
  logic [FRAC_W-1:0] hist_mem [WIN_EFF];
  logic [WIN_EFF-1:0] hist_vld_q;
  logic [SUM_W-1:0]  sum_q;
  logic [AW-1:0]     pos_q;
  logic              full_q;
  logic [WIN_W-1:0]  trans_q;
  logic [FREQ_W-1:0] cur_freq_q;

  // Per-item working registers
  in_item_t          in_q;
  logic [FRAC_W-1:0] rdata_q, old_q, nb_q, nw_q, ratio_q, avg_q;
  logic [FREQ_W-1:0] next_q;
  logic              fast_q;
  out_item_t         res_q;

  logic [AW-1:0]     rd_addr, nb_addr, nw_addr;
  logic [WIN_W-1:0]  pos_inc, count;
  logic              idle_item, sat, jump_dec, jump_inc, win_wrap;
  logic signed [TS_W-1:0] trans_sum;
  logic [WIN_W-1:0]  trans_d;
  logic [SUM_W-1:0]  sum_d;
  logic [DIV_W-1:0]  div_num, div_den;
  logic              div_done;
  logic [FRAC_W-1:0] div_quot;
  logic              fast;
  logic [FRAC_W-1:0] eff;
  logic signed [TH_W-1:0] e_s, up_hi, lo_lo, lo_hi, up_lo;
  logic [FREQ_W-1:0] next_d, fin_freq;
  logic              changed;
  logic [STATUS_W-1:0] status;

  // Window length write: zero means the default, clamp at the ring size
  always_comb begin
    win_raw = cfg_data_i[WIN_CFG_W-1:0];
    if (win_raw == '0) begin
      win_wr = W_RST;
    end else if (32'(win_raw) > WIN_EFF) begin
      win_wr = W_MAX;
    end else begin
      win_wr = WIN_W'(win_raw);
    end
  end

  always_comb begin
    idle_item = (in_q.instr_count == '0) || (in_q.cycle_count == '0);
    sat       = in_q.miss_count >= in_q.instr_count;

    pos_inc  = WIN_W'(pos_q) + 1'b1;
    win_wrap = pos_inc >= win_q;
    nb_addr  = win_wrap ? '0 : AW'(pos_inc);
    nw_addr  = (pos_q == '0) ? AW'(win_q - 1'b1) : pos_q - 1'b1;

    case (cmd_i.rd_sel)
      RD_POS:  rd_addr = pos_q;
      RD_NB:   rd_addr = nb_addr;
      RD_NW:   rd_addr = nw_addr;
      default: rd_addr = pos_q;
    endcase

    // Retire the jump leaving the window, add the one entering it
    jump_dec  = full_q && is_jump(old_q, nb_q);
    jump_inc  = (full_q || (pos_q != '0)) && is_jump(ratio_q, nw_q);
    trans_sum = $signed(TS_W'(trans_q)) + $signed(TS_W'(jump_inc))
              - $signed(TS_W'(jump_dec));
    if (trans_sum < 0) begin
      trans_d = '0;
    end else if (trans_sum > $signed(TS_W'(WIN_EFF))) begin
      trans_d = W_MAX;
    end else begin
      trans_d = WIN_W'(trans_sum);
    end
    sum_d = sum_q - SUM_W'(old_q) + SUM_W'(ratio_q);

    count = full_q ? win_q : WIN_W'(pos_q);
    if (count == '0) begin
      count = WIN_W'(1);
    end

    if (cmd_i.div_avg) begin
      div_num = DIV_W'(sum_q);
      div_den = DIV_W'({count, {FRAC_W{1'b0}}});
    end else begin
      div_num = DIV_W'(in_q.miss_count);
      div_den = DIV_W'(in_q.instr_count);
    end
  end

  mrdg_frac_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Threshold decision with hysteresis; dead zones hold the frequency
  always_comb begin
    fast  = 32'(trans_q) <= JUMP_LIMIT;
    eff   = fast ? ratio_q : avg_q;
    e_s   = $signed(TH_W'(eff));
    up_hi = $signed(TH_W'(upper_thr_q)) + $signed(TH_W'(hyst_q));
    up_lo = $signed(TH_W'(upper_thr_q)) - $signed(TH_W'(hyst_q));
    lo_hi = $signed(TH_W'(lower_thr_q)) + $signed(TH_W'(hyst_q));
    lo_lo = $signed(TH_W'(lower_thr_q)) - $signed(TH_W'(hyst_q));
    next_d = cur_freq_q;
    if (e_s > up_hi) begin
      next_d = min_freq_q;
    end else if (e_s < lo_lo) begin
      next_d = max_freq_q;
    end else if ((e_s >= lo_hi) && (e_s <= up_lo)) begin
      next_d = mid_freq_q;
    end
  end

  always_comb begin
    fin_freq = idle_item ? min_freq_q : next_q;
    changed  = fin_freq != cur_freq_q;
    if (idle_item) begin
      status = changed ? ST_CHG_IDLE : ST_IDLE;
    end else if (fast_q) begin
      status = changed ? ST_CHG_FAST : ST_FAST;
    end else begin
      status = changed ? ST_CHG_SMOOTH : ST_SMOOTH;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_thr_q <= RST_LOWER_THR;
      upper_thr_q <= RST_UPPER_THR;
      hyst_q      <= RST_HYST_BAND;
      max_freq_q  <= RST_MAX_FREQ;
      mid_freq_q  <= RST_MID_FREQ;
      min_freq_q  <= RST_MIN_FREQ;
      win_q       <= W_RST;
      hist_vld_q  <= '0;
      sum_q       <= '0;
      pos_q       <= '0;
      full_q      <= 1'b0;
      trans_q     <= '0;
      cur_freq_q  <= RST_MID_FREQ;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LOWER_THR: lower_thr_q <= cfg_data_i[FRAC_W-1:0];
          CFG_UPPER_THR: upper_thr_q <= cfg_data_i[FRAC_W-1:0];
          CFG_HYST_BAND: hyst_q      <= cfg_data_i[FRAC_W-1:0];
          CFG_MAX_FREQ:  max_freq_q  <= cfg_data_i[FREQ_W-1:0];
          CFG_MID_FREQ:  mid_freq_q  <= cfg_data_i[FREQ_W-1:0];
          CFG_MIN_FREQ:  min_freq_q  <= cfg_data_i[FREQ_W-1:0];
          CFG_WINDOW: begin
            // Drop the whole history
            win_q      <= win_wr;
            hist_vld_q <= '0;
            sum_q      <= '0;
            pos_q      <= '0;
            full_q     <= 1'b0;
            trans_q    <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        hist_vld_q[pos_q] <= 1'b1;
        sum_q             <= sum_d;
        trans_q           <= trans_d;
        if (win_wrap) begin
          pos_q  <= '0;
          full_q <= 1'b1;
        end else begin
          pos_q <= AW'(pos_inc);
        end
      end
      if (cmd_i.commit) begin
        cur_freq_q <= fin_freq;
      end
    end
  end

  // History memory and working registers
  always_ff @(posedge clk_i) begin
    rdata_q <= hist_vld_q[rd_addr] ? hist_mem[rd_addr] : '0;
    if (cmd_i.update) begin
      hist_mem[pos_q] <= ratio_q;
    end
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.cap_old) begin
      old_q <= rdata_q;
    end
    if (cmd_i.cap_nb) begin
      nb_q <= rdata_q;
    end
    if (cmd_i.cap_nw) begin
      nw_q <= rdata_q;
    end
    if (cmd_i.load_ratio) begin
      ratio_q <= sat ? {FRAC_W{1'b1}} : div_quot;
    end
    if (cmd_i.load_avg) begin
      avg_q <= div_quot;
    end
    if (cmd_i.decide) begin
      next_q <= next_d;
      fast_q <= fast;
    end
    if (cmd_i.commit) begin
      res_q.freq_khz      <= fin_freq;
      res_q.freq_changed  <= changed;
      res_q.status        <= status;
      res_q.ratio_now     <= idle_item ? '0 : ratio_q;
      res_q.ratio_average <= idle_item ? '0 : avg_q;
      res_q.jump_count    <= JUMP_W'(trans_q);
    end
  end

  assign stat_o.idle_item = idle_item;
  assign stat_o.div_done  = div_done;
  assign out_data_o       = res_q;

endmodule

`default_nettype wire

// ===== design/mrdg_ctrl.sv =====
// Controller: sequences reads, divisions, update, decision and result handoff.
`default_nettype none

module mrdg_ctrl
  import mrdg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_RD_NB,
    S_RD_NW,
    S_CAP_NW,
    S_DIV_RATIO,
    S_UPDATE,
    S_AVG_START,
    S_DIV_AVG,
    S_DECIDE,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.rd_sel = RD_POS;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        state_d = stat_i.idle_item ? S_COMMIT : S_RD_NB;
      end
      S_RD_NB: begin
        cmd_o.rd_sel  = RD_NB;
        cmd_o.cap_old = 1'b1;
        state_d       = S_RD_NW;
      end
      S_RD_NW: begin
        cmd_o.rd_sel = RD_NW;
        cmd_o.cap_nb = 1'b1;
        state_d      = S_CAP_NW;
      end
      S_CAP_NW: begin
        cmd_o.cap_nw    = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_RATIO;
      end
      S_DIV_RATIO: begin
        if (stat_i.div_done) begin
          cmd_o.load_ratio = 1'b1;
          state_d          = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_AVG_START;
      end
      S_AVG_START: begin
        cmd_o.div_avg   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (stat_i.div_done) begin
          cmd_o.load_avg = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold until the output register is free
        cmd_o.commit = !out_valid_q || out_ready_i;
        if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/miss_ratio_dvfs_governor.sv =====
// One interval is processed at a time; an idle interval skips the divisions and goes straight
// to the result. Any other interval makes two 16-step passes through the one shared fraction
// divider (miss ratio, then window average).
// A new input is taken while the previous result still waits in the output register.
// Reset: registers to defaults, history entries marked empty at once, frequency to mid.
`default_nettype none

module miss_ratio_dvfs_governor
  import mrdg_pkg::*;
#(
  parameter int WINDOW_MAX = DEFAULT_WINDOW_MAX
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mrdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mrdg_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/mrdg_checker.sv =====
// Port-level checks on the governor's result channel, bound to the top level.
`default_nettype none

module mrdg_checker
  import mrdg_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.freq_changed == ((out_data_o.status == ST_CHG_FAST) ||
                                                (out_data_o.status == ST_CHG_SMOOTH) ||
                                                (out_data_o.status == ST_CHG_IDLE)))
    else $error("freq_changed disagrees with status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_CHG_IDLE)
    else $error("status code out of range");

  a_idle_ratios: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == ST_IDLE) || (out_data_o.status == ST_CHG_IDLE))
      |-> (out_data_o.ratio_now == '0) && (out_data_o.ratio_average == '0))
    else $error("idle result carries a ratio");

endmodule

bind miss_ratio_dvfs_governor mrdg_checker u_checker (.*);

`default_nettype wire
